### sv/nfcc_pkg.sv
`default_nettype none

package nfcc_pkg;

    // device geometry
    localparam int unsigned ADDR_BITS_DEF = 17;
    localparam int unsigned SECT_SHIFT    = 12;
    localparam int unsigned BLOCK_SHIFT   = 16;

    // configuration registers
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MANUFACTURER_ID = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVICE_ID       = 1'b1;
    localparam logic [15:0] MANUFACTURER_ID_RST = 16'h00BF;
    localparam logic [15:0] DEVICE_ID_RST       = 16'h2780;

    // action codes
    localparam logic [2:0] ACT_READ_HALF   = 3'd0;
    localparam logic [2:0] ACT_READ_BYTE   = 3'd1;
    localparam logic [2:0] ACT_BUS_WRITE   = 3'd2;
    localparam logic [2:0] ACT_LOAD        = 3'd3;
    localparam logic [2:0] ACT_DIRTY_QUERY = 3'd4;
    localparam logic [2:0] ACT_CLEAR_DIRTY = 3'd5;
    localparam logic [2:0] ACT_MODE_RESET  = 3'd6;

    // command bytes
    localparam logic [7:0] CMD_UNLOCK1    = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2    = 8'h55;
    localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
    localparam logic [7:0] CMD_SOFT_ID    = 8'h90;
    localparam logic [7:0] CMD_CFI        = 8'h98;
    localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
    localparam logic [7:0] CMD_EXIT       = 8'hF0;
    localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
    localparam logic [7:0] CMD_SECT_ERASE = 8'h30;
    localparam logic [7:0] CMD_BLOCK_ERASE = 8'h50;

    // unlock halfword addresses
    localparam logic [15:0] UNLOCK_A = 16'h5555;
    localparam logic [15:0] UNLOCK_B = 16'h2AAA;

    localparam logic [15:0] ERASED_WORD = 16'hFFFF;

    // CFI query table, low part of the halfword address
    function automatic logic [15:0] cfi_word(input logic [5:0] a,
                                             input logic [15:0] abits,
                                             input logic [15:0] sects,
                                             input logic [15:0] blocks);
        logic [15:0] w;
        begin
            case (a)
                6'h10: w = 16'h0051;
                6'h11: w = 16'h0052;
                6'h12: w = 16'h0059;
                6'h13: w = 16'h0001;
                6'h14: w = 16'h0007;
                6'h1B: w = 16'h0027;
                6'h1C: w = 16'h0036;
                6'h1F: w = 16'h0004;
                6'h21: w = 16'h0004;
                6'h22: w = 16'h0006;
                6'h23: w = 16'h0001;
                6'h25: w = 16'h0001;
                6'h26: w = 16'h0001;
                6'h27: w = abits;
                6'h28: w = 16'h0001;
                6'h2C: w = 16'h0002;
                6'h2D: w = {8'h00, sects[7:0]};
                6'h2E: w = {8'h00, sects[15:8]};
                6'h2F: w = 16'h0010;
                6'h31: w = {8'h00, blocks[7:0]};
                6'h32: w = {8'h00, blocks[15:8]};
                6'h34: w = 16'h0001;
                default: w = 16'h0000;
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

### sv/nfcc_ram.sv
`default_nettype none

module nfcc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/nor_flash_command_controller_unit.sv
`default_nettype none

// Command controller of an x16 NOR flash of 2**ADDR_BITS bytes.
// Input stream: one beat per bus action (s_tuser = action code, s_tdata =
// byte address and write data). Output stream: one status beat per input beat,
// in order: read data, dirty mark of the addressed 4 KB sector, any-dirty
// flag and the command mode after the action.
// cfg_we/cfg_addr/cfg_wdata write the two software ID words; write them only
// while no beat is in flight.
// Flow: bus writes, loads and status actions go from S_IDLE straight to S_OUT;
// reads pass through S_READ (one read of the array RAM). Erases walk the RAM
// with one address counter, one halfword per cycle, through S_FILL: a sector
// erase walks its 4 KB sector, a block erase its 64 KB block, a chip erase
// the whole array. The next beat is taken the cycle after the output beat is
// taken, so a stalled receiver holds the block and its output beat stable.
// After reset the same counter erases the whole array, with s_tready low;
// configuration writes are taken during that pass. Reset clears the dirty marks
// and the mode.

module nor_flash_command_controller_unit #(
    parameter int unsigned ADDR_BITS = nfcc_pkg::ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // address[16:0], write_data[32:17], zeros
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // read_data[15:0], sector_is_dirty[16],
                                        // any_sector_dirty[17], command_mode[21:18]
    input  wire logic                              cfg_we,
    input  wire logic [nfcc_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [15:0]                       cfg_wdata
);

    localparam int unsigned HW_BITS    = ADDR_BITS - 1;
    localparam int unsigned HW_COUNT   = 1 << HW_BITS;
    localparam int unsigned SECT_BITS  = ADDR_BITS - nfcc_pkg::SECT_SHIFT;
    localparam int unsigned SECT_COUNT = 1 << SECT_BITS;
    localparam logic [15:0] CFI_ABITS  = 16'(ADDR_BITS);
    localparam logic [15:0] CFI_SECTS  = 16'(SECT_COUNT - 1);
    localparam logic [15:0] CFI_BLOCKS =
        16'((1 << (ADDR_BITS - nfcc_pkg::BLOCK_SHIFT)) - 1);
    localparam logic [HW_BITS-1:0] SECT_HW_MASK =
        HW_BITS'((1 << (nfcc_pkg::SECT_SHIFT - 1)) - 1);
    localparam logic [HW_BITS-1:0] BLOCK_HW_MASK =
        HW_BITS'((1 << (nfcc_pkg::BLOCK_SHIFT - 1)) - 1);
    localparam logic [HW_BITS-1:0] UNLOCK_A_HW = HW_BITS'(nfcc_pkg::UNLOCK_A);
    localparam logic [HW_BITS-1:0] UNLOCK_B_HW = HW_BITS'(nfcc_pkg::UNLOCK_B);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FILL,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        M_NORMAL = 4'd0,
        M_E1     = 4'd1,
        M_E2     = 4'd2,
        M_E3     = 4'd3,
        M_E4     = 4'd4,
        M_E5     = 4'd5,
        M_SWID   = 4'd6,
        M_CFI    = 4'd7,
        M_PROG   = 4'd8
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [SECT_COUNT-1:0] dirty_reg, dirty_next;
    logic                  any_reg, any_next;
    logic [HW_BITS-1:0]    ptr_reg, ptr_next;
    logic [HW_BITS-1:0]    mask_reg, mask_next;
    logic [HW_BITS-1:0]    hw_reg, hw_next;
    logic [SECT_BITS-1:0]  sect_reg, sect_next;
    logic                  byte_rd_reg, byte_rd_next;
    logic                  byte_hi_reg, byte_hi_next;
    logic [15:0]           rd_reg, rd_next;
    logic [15:0]           manu_id_reg;
    logic [15:0]           dev_id_reg;

    // input beat fields
    logic [2:0]            in_action;
    logic [15:0]           in_wd;
    logic [7:0]            in_cmd;
    logic [ADDR_BITS+16:0] addr_wide;
    logic [ADDR_BITS-1:0]  addr_eff;
    logic [HW_BITS-1:0]    in_hw;
    logic [SECT_BITS-1:0]  in_sect;

    // RAM port
    logic               ram_we;
    logic [HW_BITS-1:0] ram_addr;
    logic [15:0]        ram_wdata;
    logic [15:0]        ram_rdata;

    logic [15:0] word_rd;
    logic        walk_last;

    assign in_action = s_tuser;
    assign in_wd     = s_tdata[32:17];
    assign in_cmd    = in_wd[7:0];
    assign addr_wide = {{ADDR_BITS{1'b0}}, s_tdata[16:0]};
    assign addr_eff  = addr_wide[ADDR_BITS-1:0];
    assign in_hw     = addr_eff[ADDR_BITS-1:1];
    assign in_sect   = addr_eff[ADDR_BITS-1:nfcc_pkg::SECT_SHIFT];

    assign walk_last = (ptr_reg & mask_reg) == mask_reg;

    nfcc_ram #(
        .WIDTH (16),
        .DEPTH (HW_COUNT)
    ) u_array (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // word seen by a read, chosen by the mode at read time
    always_comb
    begin
        case (mode_reg)
            M_CFI:
            begin
                if (hw_reg[HW_BITS-1:6] == '0)
                begin
                    word_rd = nfcc_pkg::cfi_word(hw_reg[5:0], CFI_ABITS, CFI_SECTS,
                                                 CFI_BLOCKS);
                end
                else
                begin
                    word_rd = 16'h0000;
                end
            end
            M_SWID:
            begin
                if (hw_reg == HW_BITS'(0))
                begin
                    word_rd = manu_id_reg;
                end
                else if (hw_reg == HW_BITS'(1))
                begin
                    word_rd = dev_id_reg;
                end
                else
                begin
                    word_rd = 16'h0000;
                end
            end
            default: word_rd = ram_rdata;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        dirty_next   = dirty_reg;
        any_next     = any_reg;
        ptr_next     = ptr_reg;
        mask_next    = mask_reg;
        hw_next      = hw_reg;
        sect_next    = sect_reg;
        byte_rd_next = byte_rd_reg;
        byte_hi_next = byte_hi_reg;
        rd_next      = rd_reg;
        ram_we       = 1'b0;
        ram_addr     = in_hw;
        ram_wdata    = in_wd;

        case (state_reg)
            S_CLEAR, S_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg;
                ram_wdata = nfcc_pkg::ERASED_WORD;
                ptr_next  = ptr_reg + HW_BITS'(1);
                if (walk_last)
                begin
                    state_next = (state_reg == S_CLEAR) ? S_IDLE : S_OUT;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    hw_next      = in_hw;
                    sect_next    = in_sect;
                    byte_rd_next = (in_action == nfcc_pkg::ACT_READ_BYTE);
                    byte_hi_next = addr_eff[0];
                    rd_next      = 16'h0000;
                    state_next   = S_OUT;
                    case (in_action)
                        nfcc_pkg::ACT_READ_HALF, nfcc_pkg::ACT_READ_BYTE:
                        begin
                            state_next = S_READ;
                        end
                        nfcc_pkg::ACT_BUS_WRITE:
                        begin
                            if (mode_reg != M_PROG && in_cmd == nfcc_pkg::CMD_EXIT)
                            begin
                                mode_next = M_NORMAL;
                            end
                            else
                            begin
                                case (mode_reg)
                                    M_NORMAL:
                                    begin
                                        if (in_hw == UNLOCK_A_HW
                                            && in_cmd == nfcc_pkg::CMD_UNLOCK1)
                                        begin
                                            mode_next = M_E1;
                                        end
                                    end
                                    M_E1:
                                    begin
                                        mode_next = (in_hw == UNLOCK_B_HW
                                                     && in_cmd == nfcc_pkg::CMD_UNLOCK2)
                                                    ? M_E2 : M_NORMAL;
                                    end
                                    M_E2:
                                    begin
                                        mode_next = M_NORMAL;
                                        if (in_hw == UNLOCK_A_HW)
                                        begin
                                            case (in_cmd)
                                                nfcc_pkg::CMD_ERASE_SETUP: mode_next = M_E3;
                                                nfcc_pkg::CMD_SOFT_ID:     mode_next = M_SWID;
                                                nfcc_pkg::CMD_CFI:         mode_next = M_CFI;
                                                nfcc_pkg::CMD_PROGRAM:     mode_next = M_PROG;
                                                default:                   mode_next = M_NORMAL;
                                            endcase
                                        end
                                    end
                                    M_E3:
                                    begin
                                        mode_next = (in_hw == UNLOCK_A_HW
                                                     && in_cmd == nfcc_pkg::CMD_UNLOCK1)
                                                    ? M_E4 : M_NORMAL;
                                    end
                                    M_E4:
                                    begin
                                        mode_next = (in_hw == UNLOCK_B_HW
                                                     && in_cmd == nfcc_pkg::CMD_UNLOCK2)
                                                    ? M_E5 : M_NORMAL;
                                    end
                                    M_E5:
                                    begin
                                        mode_next = M_NORMAL;
                                        if (in_cmd == nfcc_pkg::CMD_CHIP_ERASE
                                            && in_hw == UNLOCK_A_HW)
                                        begin
                                            ptr_next   = '0;
                                            mask_next  = '1;
                                            dirty_next = '1;
                                            any_next   = 1'b1;
                                            state_next = S_FILL;
                                        end
                                        else if (in_cmd == nfcc_pkg::CMD_SECT_ERASE)
                                        begin
                                            ptr_next            = in_hw & ~SECT_HW_MASK;
                                            mask_next           = SECT_HW_MASK;
                                            dirty_next[in_sect] = 1'b1;
                                            any_next            = 1'b1;
                                            state_next          = S_FILL;
                                        end
                                        else if (in_cmd == nfcc_pkg::CMD_BLOCK_ERASE)
                                        begin
                                            ptr_next   = in_hw & ~BLOCK_HW_MASK;
                                            mask_next  = BLOCK_HW_MASK;
                                            // every 4 KB sector of the 64 KB block
                                            for (int i = 0; i < SECT_COUNT; i++)
                                            begin
                                                if ((SECT_BITS'(i) >> 4) == (in_sect >> 4))
                                                begin
                                                    dirty_next[i] = 1'b1;
                                                end
                                            end
                                            any_next   = 1'b1;
                                            state_next = S_FILL;
                                        end
                                    end
                                    M_PROG:
                                    begin
                                        ram_we              = 1'b1;
                                        dirty_next[in_sect] = 1'b1;
                                        any_next            = 1'b1;
                                        mode_next           = M_NORMAL;
                                    end
                                    default:
                                    begin
                                        mode_next = mode_reg;
                                    end
                                endcase
                            end
                        end
                        nfcc_pkg::ACT_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        nfcc_pkg::ACT_CLEAR_DIRTY:
                        begin
                            dirty_next = '0;
                            any_next   = 1'b0;
                        end
                        nfcc_pkg::ACT_MODE_RESET:
                        begin
                            mode_next = M_NORMAL;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (byte_rd_reg)
                begin
                    rd_next = byte_hi_reg ? {8'h00, word_rd[15:8]} : {8'h00, word_rd[7:0]};
                end
                else
                begin
                    rd_next = word_rd;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mode_reg    <= M_NORMAL;
            dirty_reg   <= '0;
            any_reg     <= 1'b0;
            ptr_reg     <= '0;
            mask_reg    <= '1;
            hw_reg      <= '0;
            sect_reg    <= '0;
            byte_rd_reg <= 1'b0;
            byte_hi_reg <= 1'b0;
            rd_reg      <= 16'h0000;
            manu_id_reg <= nfcc_pkg::MANUFACTURER_ID_RST;
            dev_id_reg  <= nfcc_pkg::DEVICE_ID_RST;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            dirty_reg   <= dirty_next;
            any_reg     <= any_next;
            ptr_reg     <= ptr_next;
            mask_reg    <= mask_next;
            hw_reg      <= hw_next;
            sect_reg    <= sect_next;
            byte_rd_reg <= byte_rd_next;
            byte_hi_reg <= byte_hi_next;
            rd_reg      <= rd_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    nfcc_pkg::CFG_MANUFACTURER_ID: manu_id_reg <= cfg_wdata;
                    nfcc_pkg::CFG_DEVICE_ID:       dev_id_reg  <= cfg_wdata;
                    default:                       manu_id_reg <= manu_id_reg;
                endcase
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b00, mode_reg, any_reg, dirty_reg[sect_reg], rd_reg};

    // any-dirty flag tracks the marks exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        any_reg == (|dirty_reg))
        else $error("any-dirty flag out of step with sector marks");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == nfcc_pkg::ACT_MODE_RESET)
        |=> (mode_reg == M_NORMAL))
        else $error("mode reset did not return to normal mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == nfcc_pkg::ACT_CLEAR_DIRTY)
        |=> (dirty_reg == '0))
        else $error("dirty marks not cleared");

    // an erase walk always ends in a status beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && walk_last) |=> (state_reg == S_OUT))
        else $error("erase walk did not hand over to the output beat");

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import nfcc_pkg::*;

    localparam int AW           = ADDR_BITS_DEF;
    localparam int HALFWORDS    = 1 << (AW - 1);
    localparam int SECTORS      = 1 << (AW - SECT_SHIFT);
    localparam int BLOCKS       = 1 << (AW - BLOCK_SHIFT);
    localparam int SECT_HW      = 1 << (SECT_SHIFT - 1);
    localparam int BLOCK_HW     = 1 << (BLOCK_SHIFT - 1);
    localparam int RANDOM_BEATS = 500;
    localparam int LONG_HOLD    = 400;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef enum logic [3:0] {
        MODE_NORMAL      = 4'd0,
        MODE_GOT_AA      = 4'd1,
        MODE_GOT_55      = 4'd2,
        MODE_ERASE_SETUP = 4'd3,
        MODE_ERASE_AA    = 4'd4,
        MODE_ERASE_55    = 4'd5,
        MODE_SOFT_ID     = 4'd6,
        MODE_CFI_QUERY   = 4'd7,
        MODE_PROGRAM     = 4'd8
    } cmd_mode_t;

    typedef struct packed {
        logic [3:0]  command_mode;
        logic        any_marked;
        logic        sector_dirty;
        logic [15:0] read_data;
    } flash_status_t;

    class flash_status_tracker;
        logic [15:0]   cells [HALFWORDS];
        bit            dirty [SECTORS];
        cmd_mode_t     mode;
        logic [15:0]   id_words [2];
        flash_status_t pending [$];
        int            errors;

        function new();
            foreach (cells[i]) cells[i] = ERASED_WORD;
            foreach (dirty[i]) dirty[i] = 1'b0;
            mode = MODE_NORMAL;
            id_words[CFG_MANUFACTURER_ID] = MANUFACTURER_ID_RST;
            id_words[CFG_DEVICE_ID] = DEVICE_ID_RST;
            errors = 0;
        endfunction

        function void set_id(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
            id_words[idx] = val;
        endfunction

        function logic [15:0] word_at(logic [15:0] hw);
            logic [15:0] w;
            w = 16'h0000;
            if (mode == MODE_CFI_QUERY)
            begin
                case (hw)
                    16'h0010: w = 16'h0051;
                    16'h0011: w = 16'h0052;
                    16'h0012: w = 16'h0059;
                    16'h0013: w = 16'h0001;
                    16'h0014: w = 16'h0007;
                    16'h001B: w = 16'h0027;
                    16'h001C: w = 16'h0036;
                    16'h001F: w = 16'h0004;
                    16'h0021: w = 16'h0004;
                    16'h0022: w = 16'h0006;
                    16'h0023: w = 16'h0001;
                    16'h0025: w = 16'h0001;
                    16'h0026: w = 16'h0001;
                    16'h0027: w = 16'(AW);
                    16'h0028: w = 16'h0001;
                    16'h002C: w = 16'h0002;
                    16'h002D: w = 16'((SECTORS - 1) & 8'hFF);
                    16'h002E: w = 16'(((SECTORS - 1) >> 8) & 8'hFF);
                    16'h002F: w = 16'h0010;
                    16'h0031: w = 16'((BLOCKS - 1) & 8'hFF);
                    16'h0032: w = 16'(((BLOCKS - 1) >> 8) & 8'hFF);
                    16'h0034: w = 16'h0001;
                    default:  w = 16'h0000;
                endcase
            end
            else if (mode == MODE_SOFT_ID)
            begin
                if (hw < 2)
                    w = id_words[hw[0]];
            end
            else
            begin
                w = cells[hw];
            end
            return w;
        endfunction

        // erase a halfword span and mark every 4 KB sector it touches
        function void wipe(int first, int count);
            for (int i = 0; i < count; i++)
                cells[(first + i) % HALFWORDS] = ERASED_WORD;
            for (int s = first / SECT_HW; s <= (first + count - 1) / SECT_HW && s < SECTORS; s++)
                dirty[s] = 1'b1;
        endfunction

        function void note_beat(logic [2:0] action, logic [16:0] addr, logic [15:0] wdata);
            flash_status_t st;
            logic [15:0]   hw;
            logic [7:0]    cmd;
            logic [15:0]   w;
            st  = '0;
            hw  = addr[16:1];
            cmd = wdata[7:0];
            case (action)
                ACT_READ_HALF: st.read_data = word_at(hw);
                ACT_READ_BYTE:
                begin
                    w = word_at(hw);
                    st.read_data = addr[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
                end
                ACT_BUS_WRITE:
                begin
                    if (mode != MODE_PROGRAM && cmd == CMD_EXIT)
                    begin
                        mode = MODE_NORMAL;
                    end
                    else
                    begin
                        case (mode)
                            MODE_NORMAL:
                                if (hw == UNLOCK_A && cmd == CMD_UNLOCK1)
                                    mode = MODE_GOT_AA;
                            MODE_GOT_AA:
                                mode = (hw == UNLOCK_B && cmd == CMD_UNLOCK2) ?
                                       MODE_GOT_55 : MODE_NORMAL;
                            MODE_GOT_55:
                            begin
                                mode = MODE_NORMAL;
                                if (hw == UNLOCK_A)
                                begin
                                    case (cmd)
                                        CMD_ERASE_SETUP: mode = MODE_ERASE_SETUP;
                                        CMD_SOFT_ID:     mode = MODE_SOFT_ID;
                                        CMD_CFI:         mode = MODE_CFI_QUERY;
                                        CMD_PROGRAM:     mode = MODE_PROGRAM;
                                        default: ;
                                    endcase
                                end
                            end
                            MODE_ERASE_SETUP:
                                mode = (hw == UNLOCK_A && cmd == CMD_UNLOCK1) ?
                                       MODE_ERASE_AA : MODE_NORMAL;
                            MODE_ERASE_AA:
                                mode = (hw == UNLOCK_B && cmd == CMD_UNLOCK2) ?
                                       MODE_ERASE_55 : MODE_NORMAL;
                            MODE_ERASE_55:
                            begin
                                if (cmd == CMD_CHIP_ERASE && hw == UNLOCK_A)
                                    wipe(0, HALFWORDS);
                                else if (cmd == CMD_SECT_ERASE)
                                    wipe(hw & ~(SECT_HW - 1), SECT_HW);
                                else if (cmd == CMD_BLOCK_ERASE)
                                    wipe(hw & ~(BLOCK_HW - 1), BLOCK_HW);
                                mode = MODE_NORMAL;
                            end
                            MODE_PROGRAM:
                            begin
                                // plain overwrite, the exit byte included
                                cells[hw] = wdata;
                                dirty[addr[16:12]] = 1'b1;
                                mode = MODE_NORMAL;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_LOAD:        cells[hw] = wdata;
                ACT_CLEAR_DIRTY: foreach (dirty[i]) dirty[i] = 1'b0;
                ACT_MODE_RESET:  mode = MODE_NORMAL;
                default: ;
            endcase
            st.sector_dirty = dirty[addr[16:12]];
            foreach (dirty[i])
                if (dirty[i])
                    st.any_marked = 1'b1;
            st.command_mode = mode;
            pending.push_back(st);
        endfunction

        function void check_beat(flash_status_t got);
            flash_status_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: status beat with none expected: %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $display("%0t: read_data expected %h got %h", $time,
                         want.read_data, got.read_data);
                errors++;
            end
            if (got.sector_dirty !== want.sector_dirty)
            begin
                $display("%0t: sector_is_dirty expected %b got %b", $time,
                         want.sector_dirty, got.sector_dirty);
                errors++;
            end
            if (got.any_marked !== want.any_marked)
            begin
                $display("%0t: any_sector_dirty expected %b got %b", $time,
                         want.any_marked, got.any_marked);
                errors++;
            end
            if (got.command_mode !== want.command_mode)
            begin
                $display("%0t: command_mode expected %0d got %0d", $time,
                         want.command_mode, got.command_mode);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [39:0]             s_tdata;
    logic [2:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [23:0]             m_tdata;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_addr;
    logic [15:0]             cfg_wdata;

    flash_status_tracker tracker = new;
    int beats_sent;
    int burst_left;
    int block_erases_left;
    bit long_hold_req;

    nor_flash_command_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_beat(flash_status_t'(m_tdata[21:0]));
    end

    // receiver: changes stall style every so often, long hold on request
    initial
    begin : receiver
        int style;
        int style_left;
        int hold_left;
        m_tready = 1'b0;
        style = 0;
        style_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(16, 200);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    function automatic logic [16:0] any_addr();
        return 17'($urandom);
    endfunction

    function automatic logic [16:0] at_hw(logic [15:0] hw);
        return {hw, 1'($urandom_range(0, 1))};
    endfunction

    // one input beat; the sender runs in bursts with random gaps between
    task automatic send_beat(logic [2:0] action, logic [16:0] addr, logic [15:0] wdata);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'b0, wdata, addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_beat(action, addr, wdata);
        beats_sent++;
        burst_left--;
    endtask

    task automatic write_cmd(logic [15:0] hw, logic [7:0] cmd);
        send_beat(ACT_BUS_WRITE, at_hw(hw), {8'($urandom), cmd});
    endtask

    task automatic unlock();
        write_cmd(UNLOCK_A, CMD_UNLOCK1);
        write_cmd(UNLOCK_B, CMD_UNLOCK2);
    endtask

    task automatic read_back(logic [16:0] addr);
        send_beat($urandom_range(0, 1) ? ACT_READ_BYTE : ACT_READ_HALF, addr, 16'($urandom));
    endtask

    task automatic leave_mode();
        if ($urandom_range(0, 1))
            write_cmd(16'($urandom), CMD_EXIT);
        else
            send_beat(ACT_MODE_RESET, any_addr(), 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_ids(logic [15:0] mfr, logic [15:0] dev);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MANUFACTURER_ID;
        cfg_wdata <= mfr;
        @(posedge clk);
        tracker.set_id(CFG_MANUFACTURER_ID, mfr);
        cfg_addr  <= CFG_DEVICE_ID;
        cfg_wdata <= dev;
        @(posedge clk);
        tracker.set_id(CFG_DEVICE_ID, dev);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_traffic(int stop_at);
        int          kind;
        int          n;
        logic [16:0] a;
        logic [7:0]  b;
        logic [15:0] seq_hw [5];
        logic [7:0]  seq_cmd [5];
        seq_hw  = '{UNLOCK_A, UNLOCK_B, UNLOCK_A, UNLOCK_A, UNLOCK_B};
        seq_cmd = '{CMD_UNLOCK1, CMD_UNLOCK2, CMD_ERASE_SETUP, CMD_UNLOCK1, CMD_UNLOCK2};
        while (beats_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            a = any_addr();
            if (kind < 22)
            begin
                unlock();
                write_cmd(UNLOCK_A, CMD_PROGRAM);
                send_beat(ACT_BUS_WRITE, a, 16'($urandom));
                read_back(a ^ 17'($urandom_range(0, 1)));
            end
            else if (kind < 34)
            begin
                unlock();
                write_cmd(UNLOCK_A, CMD_SOFT_ID);
                n = $urandom_range(1, 4);
                repeat (n) read_back(at_hw(16'($urandom_range(0, 3))));
                if ($urandom_range(0, 2) == 0)
                begin
                    do b = 8'($urandom); while (b == CMD_EXIT);
                    write_cmd(a[16:1], b);
                end
                leave_mode();
            end
            else if (kind < 46)
            begin
                unlock();
                write_cmd(UNLOCK_A, CMD_CFI);
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        read_back(any_addr());
                    else
                        read_back(at_hw(16'($urandom_range(16'h000E, 16'h0036))));
                end
                leave_mode();
            end
            else if (kind < 60)
            begin
                unlock();
                write_cmd(UNLOCK_A, CMD_ERASE_SETUP);
                unlock();
                n = $urandom_range(0, 9);
                if ((n == 6 || n == 7) && block_erases_left > 0)
                begin
                    block_erases_left--;
                    write_cmd(a[16:1], CMD_BLOCK_ERASE);
                end
                else if (n == 8)
                begin
                    // chip erase byte away from the unlock address: no erase
                    if (a[16:1] == UNLOCK_A)
                        a[1] = ~a[1];
                    write_cmd(a[16:1], CMD_CHIP_ERASE);
                end
                else if (n == 9)
                begin
                    do b = 8'($urandom);
                    while (b == CMD_CHIP_ERASE || b == CMD_SECT_ERASE || b == CMD_BLOCK_ERASE);
                    write_cmd(a[16:1], b);
                end
                else
                begin
                    write_cmd(a[16:1], CMD_SECT_ERASE);
                end
                read_back(a);
            end
            else if (kind < 70)
            begin
                // unlock / erase-setup sequence broken at a random step
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++)
                    write_cmd(seq_hw[k], seq_cmd[k]);
                if ($urandom_range(0, 1))
                begin
                    write_cmd(seq_hw[n] ^ 16'($urandom_range(1, 16'hFFFF)), seq_cmd[n]);
                end
                else
                begin
                    do b = 8'($urandom);
                    while (b == seq_cmd[n] || b == CMD_ERASE_SETUP || b == CMD_SOFT_ID ||
                           b == CMD_CFI || b == CMD_PROGRAM);
                    write_cmd(seq_hw[n], b);
                end
                read_back(a);
            end
            else if (kind < 80)
            begin
                send_beat(ACT_LOAD, a, 16'($urandom));
                read_back(a);
            end
            else if (kind < 88)
            begin
                send_beat(($urandom_range(0, 3) == 0) ? ACT_CLEAR_DIRTY : ACT_DIRTY_QUERY,
                          a, 16'($urandom));
            end
            else
            begin
                send_beat(3'($urandom), a, 16'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        beats_sent = 0;
        burst_left = 0;
        block_erases_left = 2;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset ID words still in place
        send_beat(ACT_LOAD, 17'h1FFFF, 16'hA5C3);
        send_beat(ACT_READ_BYTE, 17'h1FFFF, 16'h0000);
        unlock();
        write_cmd(UNLOCK_A, CMD_SOFT_ID);
        send_beat(ACT_READ_HALF, 17'h00000, 16'hFFFF);
        send_beat(ACT_READ_BYTE, 17'h00003, 16'h0000);
        write_cmd(UNLOCK_B, CMD_EXIT);
        unlock();
        write_cmd(UNLOCK_A, CMD_CFI);
        send_beat(ACT_READ_HALF, 17'h0004E, 16'h0000);
        send_beat(ACT_MODE_RESET, 17'h1FFFF, 16'h0000);
        unlock();
        write_cmd(UNLOCK_A, CMD_PROGRAM);
        send_beat(ACT_BUS_WRITE, 17'h1FFFE, 16'h00F0);
        send_beat(ACT_READ_HALF, 17'h1FFFF, 16'h0000);
        send_beat(ACT_UNUSED, 17'h00000, 16'hFFFF);
        unlock();
        write_cmd(UNLOCK_A, CMD_ERASE_SETUP);
        unlock();
        write_cmd(UNLOCK_A, CMD_CHIP_ERASE);
        send_beat(ACT_DIRTY_QUERY, 17'h10000, 16'h0000);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:       write_ids(16'hFFFF, 16'h0000);
                1:       write_ids(16'h0000, 16'hFFFF);
                default: write_ids(16'($urandom), 16'($urandom));
            endcase
            if (phase == 1)
                long_hold_req = 1'b1;
            random_traffic(beats_sent + RANDOM_BEATS / 4);
        end

        drain();
        repeat (50) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
